// ----- rtl/id_allocator_delayed_reuse_unit_defines.svh -----
// Assertion macros for the ID allocator checker.
`ifndef ID_ALLOCATOR_DELAYED_REUSE_UNIT_DEFINES_SVH
`define ID_ALLOCATOR_DELAYED_REUSE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define IDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define IDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/ida_pkg.sv -----
// Package: types and constants for the ID allocator.
`timescale 1ns / 1ps
package ida_pkg;
    localparam int BitmapWords = 1024;
    localparam int QueueDepth  = 1024;
    localparam int BwAw        = $clog2(BitmapWords);
    localparam int QdAw        = $clog2(QueueDepth);
    localparam int IdW         = 15;
    localparam int CntW        = 11;
    localparam int HintW       = $clog2(BitmapWords + 1);
    localparam int QcW         = $clog2(QueueDepth + 1);
    localparam logic [31:0] FullWord  = 32'hFFFF_FFFF;
    localparam logic [31:0] DelayRst  = 32'd86400;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0, FN_RELEASE = 2'd1, FN_SWEEP = 2'd2, FN_MARK = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NO_ID = 2'd1, ST_Q_FULL = 2'd2, ST_MISMATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_SWP_RD, S_SWP_CHK, S_SWP_BM, S_OUT
    } t_state;

    // bitmap memory request
    typedef struct packed {
        logic             wr_en;
        logic [BwAw-1:0]  wr_addr;
        logic [31:0]      wr_data;
        logic [BwAw-1:0]  rd_addr;
    } t_bm_req;
endpackage

// ----- rtl/ida_bitmap_ram.sv -----
// Bitmap word memory, one write and one registered read port.
`timescale 1ns / 1ps
module ida_bitmap_ram
    import ida_pkg::*;
(
    input  logic        i_clk,
    input  t_bm_req     i_req,
    output logic [31:0] o_rd_data
);
    logic [31:0] r_mem [BitmapWords];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_rd_data <= r_mem[i_req.rd_addr];
    end
endmodule

// ----- rtl/ida_queue_ram.sv -----
// Release queue storage: ID and timestamp per entry.
`timescale 1ns / 1ps
module ida_queue_ram
    import ida_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [QdAw-1:0]  i_wr_addr,
    input  logic [IdW-1:0]   i_wr_id,
    input  logic [31:0]      i_wr_time,
    input  logic [QdAw-1:0]  i_rd_addr,
    output logic [IdW-1:0]   o_rd_id,
    output logic [31:0]      o_rd_time
);
    logic [IdW+31:0] r_mem [QueueDepth];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_id, i_wr_time};
        end
        {o_rd_id, o_rd_time} <= r_mem[i_rd_addr];
    end
endmodule

// ----- rtl/id_allocator_delayed_reuse_unit.sv -----
// Top level of the bitmap ID allocator with delayed reuse.
`timescale 1ns / 1ps
// One item at a time. After reset a clearing pass writes all 1024 bitmap
// words before the first item is accepted. Allocate reads bitmap words in
// turn from the hint until one has a clear bit or none is left. Release
// writes the queue. Mark-used reads the word of the ID and sets its bit.
// Sweep reads the queue head, checks whether it is due and, if so, clears
// its bit in the bitmap, one entry after another, since each memory has a
// single read port. A result waits in the output register; the next item
// is taken once it has been delivered.
module id_allocator_delayed_reuse_unit
    import ida_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_func,
    input  logic [IdW-1:0]  i_id,
    input  logic [31:0]     i_timestamp,
    input  logic [CntW-1:0] i_expected_count,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [IdW-1:0]  o_new_id,
    output logic [CntW-1:0] o_freed_count,
    output logic [1:0]      o_status,
    output logic [IdW-1:0]  o_highest_id
);
    t_state r_state, n_state;
    logic [31:0]      r_delay;
    logic [HintW-1:0] r_hint, n_hint;
    logic [IdW-1:0]   r_max, n_max;
    logic [QdAw-1:0]  r_head, n_head, r_tail, n_tail;
    logic [QcW-1:0]   r_qcnt, n_qcnt;
    logic [BwAw-1:0]  r_clr, n_clr;
    logic [1:0]       r_func;
    logic [31:0]      r_ts;
    logic [CntW-1:0]  r_exp;
    logic [QcW-1:0]   r_freed, n_freed;
    logic [IdW-1:0]   r_qid, n_qid;
    logic             r_ovalid, n_ovalid;
    logic [IdW-1:0]   r_onew, n_onew;
    logic [CntW-1:0]  r_ofreed, n_ofreed;
    logic [1:0]       r_ostat, n_ostat;
    logic             r_q_ok;
    t_bm_req          w_bm;
    logic [31:0]      w_bm_rd;
    logic             w_q_we;
    logic [IdW-1:0]   w_q_id;
    logic [31:0]      w_q_time;
    logic [4:0]       w_bit;
    logic [IdW-1:0]   w_full_id;
    logic             w_take;
    logic             w_in_range;
    logic [32:0]      w_due;

    ida_bitmap_ram u_bm (.i_clk(i_clk), .i_req(w_bm), .o_rd_data(w_bm_rd));

    ida_queue_ram u_q (
        .i_clk(i_clk), .i_wr_en(w_q_we), .i_wr_addr(r_tail),
        .i_wr_id(i_id), .i_wr_time(i_timestamp), .i_rd_addr(r_head),
        .o_rd_id(w_q_id), .o_rd_time(w_q_time)
    );

    assign o_ready       = (r_state == S_IDLE) && !r_ovalid;
    assign w_take        = i_valid && o_ready;
    assign o_valid       = r_ovalid;
    assign o_new_id      = r_onew;
    assign o_freed_count = r_ofreed;
    assign o_status      = r_ostat;
    assign o_highest_id  = r_max;
    assign w_q_we        = w_take && (t_func'(i_func) == FN_RELEASE)
                           && (r_qcnt < QcW'(QueueDepth));
    assign w_due         = {1'b0, w_q_time} + {1'b0, r_delay};
    assign w_in_range    = (32'(r_qid) >> 5) < 32'(BitmapWords);

    // lowest clear bit, bit 31 if all lower set
    always_comb begin
        w_bit = 5'd31;
        for (int b = 30; b >= 0; b--) begin
            if (!w_bm_rd[b]) begin
                w_bit = 5'(b);
            end
        end
    end
    assign w_full_id = IdW'({r_hint[BwAw-1:0], w_bit});

    // control
    always_comb begin
        n_state  = r_state;
        n_hint   = r_hint;
        n_max    = r_max;
        n_head   = r_head;
        n_tail   = r_tail;
        n_qcnt   = r_qcnt;
        n_clr    = r_clr;
        n_freed  = r_freed;
        n_qid    = r_qid;
        n_ovalid = r_ovalid && !i_ready;
        n_onew   = r_onew;
        n_ofreed = r_ofreed;
        n_ostat  = r_ostat;
        w_bm     = '0;
        w_bm.rd_addr = r_hint[BwAw-1:0];
        case (r_state)
            S_CLEAR: begin
                w_bm.wr_en   = 1'b1;
                w_bm.wr_addr = r_clr;
                w_bm.wr_data = (r_clr == '0) ? 32'd1 : 32'd0;
                n_clr        = r_clr + 1'b1;
                if (r_clr == BwAw'(BitmapWords - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    n_freed = '0;
                    case (t_func'(i_func))
                        FN_ALLOC: begin
                            if (r_hint >= HintW'(BitmapWords)) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FN_RELEASE: begin
                            if (r_qcnt < QcW'(QueueDepth)) begin
                                n_tail = (r_tail == QdAw'(QueueDepth - 1)) ? '0
                                         : r_tail + 1'b1;
                                n_qcnt = r_qcnt + 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        FN_SWEEP: n_state = S_SWP_RD;
                        FN_MARK: begin
                            w_bm.rd_addr = BwAw'(i_id >> 5);
                            n_state = S_SWP_BM;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SCAN: begin
                // r_hint word is on the read port
                if (w_bm_rd == FullWord) begin
                    n_hint = r_hint + 1'b1;
                    w_bm.rd_addr = n_hint[BwAw-1:0];
                    if (n_hint >= HintW'(BitmapWords)) begin
                        n_state = S_OUT;
                    end
                end else begin
                    w_bm.wr_en   = 1'b1;
                    w_bm.wr_addr = r_hint[BwAw-1:0];
                    w_bm.wr_data = w_bm_rd | (32'd1 << w_bit);
                    if (w_full_id > r_max) begin
                        n_max = w_full_id;
                    end
                    n_onew  = w_full_id;
                    n_ostat = ST_OK;
                    n_ofreed = '0;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SWP_RD: begin
                // queue head read issued, data next cycle
                if (r_qcnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SWP_CHK;
                end
            end
            S_SWP_CHK: begin
                if (w_due < {1'b0, r_ts}) begin
                    n_qid = w_q_id;
                    w_bm.rd_addr = BwAw'(w_q_id >> 5);
                    n_head  = (r_head == QdAw'(QueueDepth - 1)) ? '0 : r_head + 1'b1;
                    n_qcnt  = r_qcnt - 1'b1;
                    n_freed = r_freed + 1'b1;
                    n_state = S_SWP_BM;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SWP_BM: begin
                // word of r_qid is on the read port: clear or set its bit
                if (w_in_range) begin
                    w_bm.wr_en   = 1'b1;
                    w_bm.wr_addr = BwAw'(r_qid >> 5);
                    if (t_func'(r_func) == FN_MARK) begin
                        w_bm.wr_data = w_bm_rd | (32'd1 << r_qid[4:0]);
                    end else begin
                        w_bm.wr_data = w_bm_rd & ~(32'd1 << r_qid[4:0]);
                        if (HintW'(r_qid >> 5) < r_hint) begin
                            n_hint = HintW'(r_qid >> 5);
                        end
                    end
                end
                if (t_func'(r_func) == FN_MARK) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SWP_RD;
                end
            end
            S_OUT: begin
                n_onew   = '0;
                n_ofreed = CntW'(r_freed);
                n_ostat  = ST_OK;
                case (t_func'(r_func))
                    FN_ALLOC: n_ostat = ST_NO_ID;
                    FN_RELEASE: begin
                        if (r_qcnt == QcW'(QueueDepth) && !r_q_ok) n_ostat = ST_Q_FULL;
                    end
                    FN_SWEEP: begin
                        if (r_freed != QcW'(r_exp)) n_ostat = ST_MISMATCH;
                    end
                    default: n_ostat = ST_OK;
                endcase
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // release accepted into queue
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_q_ok <= w_q_we;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_func <= i_func;
            r_ts   <= i_timestamp;
            r_exp  <= i_expected_count;
        end
        r_onew   <= n_onew;
        r_ofreed <= n_ofreed;
        r_ostat  <= n_ostat;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_delay  <= DelayRst;
            r_hint   <= '0;
            r_max    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_qcnt   <= '0;
            r_clr    <= '0;
            r_freed  <= '0;
            r_qid    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
            r_state  <= n_state;
            r_hint   <= n_hint;
            r_max    <= n_max;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_qcnt   <= n_qcnt;
            r_clr    <= n_clr;
            r_freed  <= n_freed;
            r_qid    <= (w_take && t_func'(i_func) == FN_MARK) ? i_id : n_qid;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ----- rtl/ida_checker.sv -----
// Port checker for the ID allocator, bound to the top level.
`timescale 1ns / 1ps
`include "id_allocator_delayed_reuse_unit_defines.svh"
module ida_checker
    import ida_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input logic [IdW-1:0]  o_new_id,
    input logic [1:0]      o_status,
    input logic [IdW-1:0]  o_highest_id
);
    // a held result stays valid and keeps its status
    `IDA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    // one item in flight: no accept while a result waits
    `IDA_ASSERT_IMP(a_one_item, i_clk, i_rst_n, o_valid, !o_ready)
    // highest ID never falls
    `IDA_ASSERT_NXT(a_max_mono, i_clk, i_rst_n, 1'b1, o_highest_id >= $past(o_highest_id))
    // a handed-out ID never exceeds the highest
    `IDA_ASSERT_IMP(a_new_le_max, i_clk, i_rst_n, o_valid, o_new_id <= o_highest_id)
endmodule

bind id_allocator_delayed_reuse_unit ida_checker u_ida_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_new_id(o_new_id),
    .o_status(o_status), .o_highest_id(o_highest_id)
);
